>>> hw/rtl/bpa_pkg.sv
package bpa_pkg;

  // Map geometry.
  localparam int PAGES      = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);

  // Field widths.
  localparam int REQ_W   = 2;
  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;

  // Request kinds; the fourth code is an unknown request that changes nothing.
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_SAME_STATE = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the request and select the map word
    logic eval;   // update the map and load the result register
  } bpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic map_busy;  // a map word read is outstanding
  } bpa_stat_t;

endpackage

>>> hw/rtl/bpa_ctrl.sv
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.eval = (state_r == S_EVAL) && out_free && !stat.map_busy;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (cmd.eval) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |=> out_valid_r)
    else $error("result not presented after evaluation");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_READ))
    else $error("accepted beat did not start a map read");

  a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EVAL))
    else $error("map read not followed by evaluation");

endmodule

>>> hw/rtl/bpa_dpath.sv
module bpa_dpath
  import bpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bpa_cmd_t           cmd,
  output bpa_stat_t          stat,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_total,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [PAGE_W-1:0]  in_page_number,
  output logic [1:0]         out_status,
  output logic [PAGE_W-1:0]  out_granted_page,
  output logic [COUNT_W-1:0] out_free_pages
);

  localparam logic [COUNT_W-1:0] PAGES_C = COUNT_W'(PAGES);

  // Used map storage and per-word summary bits.
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_r;
  logic [MAP_WORDS-1:0] full_r;

  logic [COUNT_W-1:0]    total_r;
  logic [COUNT_W-1:0]    used_count_r, used_count_nxt;
  logic [REQ_W-1:0]      req_r;
  logic [PAGE_W-1:0]     page_r;
  logic [WORD_IDX_W-1:0] addr_r, addr_nxt;
  logic                  none_r;
  logic [WORD_BITS-1:0]  rd_data_r;
  logic                  rd_valid_r;
  logic                  rd_pend_r;

  logic [WORD_IDX_W-1:0] first_word;
  logic [BIT_IDX_W-1:0]  first_bit;
  logic [WORD_BITS-1:0]  word, new_word;
  logic [COUNT_W-1:0]    lim;
  logic [PAGE_W-1:0]     alloc_page;
  logic [BIT_IDX_W-1:0]  bit_sel;
  logic                  wr_en;
  status_t               status_nxt;
  logic [PAGE_W-1:0]     granted_nxt;
  logic [COUNT_W-1:0]    free_nxt;

  logic [1:0]            out_status_r;
  logic [PAGE_W-1:0]     out_granted_r;
  logic [COUNT_W-1:0]    out_free_r;

  assign stat.map_busy = rd_pend_r;

  // Lowest word that still has a free page.
  always_comb begin
    first_word = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        first_word = WORD_IDX_W'(i);
      end
    end
  end

  always_comb begin
    addr_nxt = in_page_number[PAGE_W-1:BIT_IDX_W];
    if (in_req_type == REQ_ALLOC) begin
      addr_nxt = first_word;
    end
  end

  assign word = rd_valid_r ? rd_data_r : '0;

  // Lowest free bit in the selected word.
  always_comb begin
    first_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!word[j]) begin
        first_bit = BIT_IDX_W'(j);
      end
    end
  end

  assign lim        = (total_r > PAGES_C) ? PAGES_C : total_r;
  assign alloc_page = {addr_r, first_bit};
  assign bit_sel    = page_r[BIT_IDX_W-1:0];

  always_comb begin
    new_word       = word;
    wr_en          = 1'b0;
    used_count_nxt = used_count_r;
    status_nxt     = ST_OK;
    granted_nxt    = '0;
    if (req_r == REQ_ALLOC) begin
      if (!none_r && (COUNT_W'(alloc_page) < lim)) begin
        new_word[first_bit] = 1'b1;
        wr_en               = 1'b1;
        used_count_nxt      = used_count_r + COUNT_W'(1);
        granted_nxt         = alloc_page;
      end else begin
        status_nxt = ST_NO_FREE;
      end
    end else if (req_r == REQ_FREE || req_r == REQ_RESERVE) begin
      if (COUNT_W'(page_r) >= lim) begin
        status_nxt = ST_RANGE;
      end else if (word[bit_sel] == (req_r == REQ_RESERVE)) begin
        status_nxt = ST_SAME_STATE;
      end else begin
        new_word[bit_sel] = (req_r == REQ_RESERVE);
        wr_en             = 1'b1;
        if (req_r == REQ_RESERVE) begin
          used_count_nxt = used_count_r + COUNT_W'(1);
        end else begin
          used_count_nxt = used_count_r - COUNT_W'(1);
        end
      end
    end
    free_nxt = (lim > used_count_nxt) ? (lim - used_count_nxt) : '0;
  end

  // Map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.eval && wr_en) begin
      mem[addr_r] <= new_word;
    end
    rd_data_r  <= mem[addr_r];
    rd_valid_r <= valid_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      full_r       <= '0;
      used_count_r <= '0;
      total_r      <= PAGES_C;
      rd_pend_r    <= 1'b0;
    end else begin
      rd_pend_r <= cmd.load;
      if (cfg_we) begin
        total_r <= cfg_total;
      end
      if (cmd.eval && wr_en) begin
        valid_r[addr_r] <= 1'b1;
        full_r[addr_r]  <= &new_word;
        used_count_r    <= used_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      page_r <= in_page_number;
      addr_r <= addr_nxt;
      none_r <= &full_r;
    end
    if (cmd.eval) begin
      out_status_r  <= status_nxt;
      out_granted_r <= granted_nxt;
      out_free_r    <= free_nxt;
    end
  end

  assign out_status       = out_status_r;
  assign out_granted_page = out_granted_r;
  assign out_free_pages   = out_free_r;

  a_full_implies_written: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r & ~valid_r) == '0)
    else $error("word marked full but never written");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= PAGES_C)
    else $error("used page count exceeds the map size");

endmodule

>>> hw/rtl/bitmap_page_allocator_core.sv
// Bitmap first-fit page allocator.
// Request beats enter on in_valid / in_stall with a request kind (allocate,
// free, reserve) and a page number. Each accepted beat yields exactly one
// result beat on out_valid / out_stall carrying a status, the granted page
// and the free page count after the request.
// The one configuration register, the managed page total, is written on
// cfg_valid / cfg_ready; cfg_ready is always high. Write it only while idle.
// A request beat passes the request registers, the registered map word read
// and the result register before its result beat is presented. One request
// is worked on at a time, so the block takes a new beat only once the last
// one is evaluated. The steps follow the single map memory port: the accept
// step picks the word (a per-word full summary locates the first word with a
// free page), the next does the registered word read, and the last priority
// encodes, writes back and loads the result register.
// A finished result waits in its output register; the next request beat is
// accepted meanwhile and is held at evaluation while the receiver stalls.
// Synchronous reset clears the whole map at once through per-word valid
// bits, zeroes the used count and sets the page total to the map size; the
// block accepts beats in the first cycle after reset.
module bitmap_page_allocator_core
  import bpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [PAGE_W-1:0]  in_page_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [PAGE_W-1:0]  out_granted_page,
  output logic [COUNT_W-1:0] out_free_pages,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_total_pages
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_total        (cfg_total_pages),
    .in_req_type      (in_req_type),
    .in_page_number   (in_page_number),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_free_pages   (out_free_pages)
  );

endmodule

>>> tb/tb_top.sv
module tb_top
  import bpa_pkg::*;
();

  // The fourth request code has no meaning. The block must answer it and leave
  // its state alone.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Every request yields one answer once it has been accepted. This constant
  // is the quiet time we allow before a total change and at the very end.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [PAGE_W-1:0] page;
  } page_request_t;

  typedef struct {
    status_t            status;
    logic [PAGE_W-1:0]  granted;
    logic [COUNT_W-1:0] free_cnt;
  } page_answer_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   in_req_type      = '0;
  logic [PAGE_W-1:0]  in_page_number   = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [1:0]         out_status;
  logic [PAGE_W-1:0]  out_granted_page;
  logic [COUNT_W-1:0] out_free_pages;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_total_pages  = '0;

  // This is our own copy of the allocator state. The driver updates it as each
  // request beat is accepted.
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [COUNT_W-1:0]   shadow_used;
  logic [COUNT_W-1:0]   shadow_total;

  page_request_t request_q[$];       // requests not yet presented to the block
  page_answer_t  pending_answers[$]; // answers owed by the block, oldest first
  int            items_waiting = 0;  // requests queued but not yet accepted
  bit            traffic_quiet = 1'b0;
  int            error_count   = 0;
  int            cycle_count   = 0;
  int            answers_seen  = 0;
  int            grants_seen   = 0;
  int            refusals_seen = 0;
  int            gap_left;
  int            stall_left;

  bitmap_page_allocator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_free_pages   (out_free_pages),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_total_pages  (cfg_total_pages)
  );

  always #6 clk = ~clk;

  // This applies one request to the shadow state and returns the answer the
  // block owes for it. The effective total is capped at the map size. An
  // allocate takes the lowest free page below that total. A free or reserve
  // of a page at or above the total is refused and changes nothing. The free
  // count stops at zero, because pages used above a lowered total are still
  // counted as used.
  function automatic page_answer_t serve_request(input logic [REQ_W-1:0] kind,
                                                 input logic [PAGE_W-1:0] page);
    page_answer_t ans;
    int           lim;
    int           grant;
    bit           found;
    bit           want_used;
    ans.status   = ST_OK;
    ans.granted  = '0;
    lim          = (shadow_total > PAGES) ? PAGES : int'(shadow_total);
    found        = 1'b0;
    grant        = 0;
    if (kind == REQ_ALLOC) begin
      for (int p = 0; p < lim; p++) begin
        if (!found && !shadow_map[p / WORD_BITS][p % WORD_BITS]) begin
          found = 1'b1;
          grant = p;
        end
      end
      if (found) begin
        shadow_map[grant / WORD_BITS][grant % WORD_BITS] = 1'b1;
        shadow_used++;
        ans.granted = PAGE_W'(grant);
      end else begin
        ans.status = ST_NO_FREE;
      end
    end else if (kind == REQ_FREE || kind == REQ_RESERVE) begin
      want_used = (kind == REQ_RESERVE);
      if (int'(page) >= lim) begin
        ans.status = ST_RANGE;
      end else if (shadow_map[page / WORD_BITS][page % WORD_BITS] == want_used) begin
        ans.status = ST_SAME_STATE;
      end else begin
        shadow_map[page / WORD_BITS][page % WORD_BITS] = want_used;
        if (want_used) begin
          shadow_used++;
        end else begin
          shadow_used--;
        end
      end
    end
    ans.free_cnt = (lim > int'(shadow_used)) ? COUNT_W'(lim - int'(shadow_used)) : '0;
    return ans;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      flag_error($sformatf("%s expected %0d, got %0d", field, want, got));
    end
  endtask

  // Request driver. Accepted beats go through the shadow model right away, so
  // the expected answers stay in the same order as the beats. A stalled beat
  // is held exactly as it is. Otherwise the driver either sits out the rest
  // of an idle burst or presents the next queued request.
  always @(posedge clk) begin : drive_requests
    page_request_t next_req;
    logic          present;
    if (!rst_n) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        shadow_map[w] = '0;
      end
      shadow_used  = '0;
      shadow_total = COUNT_W'(PAGES);
      gap_left     = 0;
      in_valid <= 1'b0;
    end else begin
      // A total write lands only while the block is idle. Capturing it here
      // keeps it in order with the request beats.
      if (cfg_valid && cfg_ready) begin
        shadow_total = cfg_total_pages;
      end
      if (in_valid && !in_stall) begin
        pending_answers.push_back(serve_request(in_req_type, in_page_number));
        items_waiting--;
      end
      if (!(in_valid && in_stall)) begin
        present = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          next_req = request_q.pop_front();
          in_req_type    <= next_req.kind;
          in_page_number <= next_req.page;
          present = 1'b1;
          if (!traffic_quiet && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 3);
          end
        end
        in_valid <= present;
      end
    end
  end

  // The answer side stalls in short random bursts. This lets finished answers
  // wait in the output register while the next request is already accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!traffic_quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Answer monitor. Each accepted answer beat is compared field by field with
  // the oldest answer still owed.
  always @(posedge clk) begin : check_answers
    page_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (status_t'(out_status) == ST_OK && out_granted_page != '0) begin
        grants_seen++;
      end
      if (status_t'(out_status) == ST_NO_FREE) begin
        refusals_seen++;
      end
      if (pending_answers.size() == 0) begin
        flag_error("answer beat with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        check_field("status", want.status, out_status);
        check_field("granted_page", want.granted, out_granted_page);
        check_field("free_pages", want.free_cnt, out_free_pages);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d answers still owed",
               cycle_count, pending_answers.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_request(input logic [REQ_W-1:0] kind, input int page);
    page_request_t req;
    req.kind = kind;
    req.page = PAGE_W'(page);
    request_q.push_back(req);
    items_waiting++;
  endtask

  // This waits until every queued request has been accepted and answered.
  // It then lets the block settle before returning.
  task automatic wait_idle();
    while (items_waiting != 0 || pending_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input int total);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_total_pages <= COUNT_W'(total);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic mixes the request kinds. Most pages fall in a hot range
  // near the bottom, where allocations land, so that frees and reserves
  // often hit used pages. Some pages sit right on the total's boundary, and
  // some are drawn from the full 12-bit range.
  task automatic queue_random(input int count, input int span);
    int kind_roll;
    int hot;
    int page;
    logic [REQ_W-1:0] kind;
    hot = (span < 1) ? 1 : ((span > 192) ? 192 : span);
    for (int i = 0; i < count; i++) begin
      kind_roll = $urandom_range(0, 19);
      if (kind_roll < 8) begin
        kind = REQ_ALLOC;
      end else if (kind_roll < 13) begin
        kind = REQ_FREE;
      end else if (kind_roll < 18) begin
        kind = REQ_RESERVE;
      end else begin
        kind = REQ_UNKNOWN;
      end
      case ($urandom_range(0, 9))
        0: page = $urandom_range(0, 4095);
        1: page = (span > 4095) ? 4095 : span - $urandom_range(0, 1);
        default: page = $urandom_range(0, hot - 1);
      endcase
      if (page < 0) begin
        page = 0;
      end
      queue_request(kind, page);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A total above the map size must act as the full map.
    write_total(8191);
    queue_request(REQ_ALLOC, 4095);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 1);
    queue_request(REQ_FREE, 1);        // already free
    queue_request(REQ_ALLOC, 0);       // the hole at page one is reused
    queue_request(REQ_RESERVE, 4095);
    queue_request(REQ_RESERVE, 4095);  // already used
    queue_request(REQ_FREE, 4095);
    queue_request(REQ_UNKNOWN, 4095);
    queue_request(REQ_RESERVE, 3);
    queue_request(REQ_ALLOC, 0);
    wait_idle();

    // With a tiny total, every managed page is used and the allocator is exhausted.
    write_total(5);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 5);
    queue_request(REQ_RESERVE, 4095);
    queue_request(REQ_FREE, 4);
    queue_request(REQ_ALLOC, 0);
    wait_idle();

    // A total of zero puts every page out of range.
    write_total(0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_RESERVE, 0);
    wait_idle();

    // Here the total drops below the pages in use, so the free count stops at zero.
    write_total(3);
    queue_request(REQ_FREE, 2);
    queue_request(REQ_RESERVE, 2);
    queue_request(REQ_ALLOC, 0);
    wait_idle();

    // The random phases below use a range of totals. Each phase drains fully
    // before the total is rewritten, so the sender is held off until every
    // owed answer has arrived.
    write_total(4096);
    queue_random(90, 4096);
    wait_idle();
    write_total(40);
    queue_random(80, 40);
    wait_idle();
    write_total(1);
    queue_random(30, 1);
    wait_idle();
    write_total(100);
    queue_random(90, 100);
    wait_idle();
    write_total(33);
    queue_random(60, 33);
    wait_idle();

    // The last phase runs with no idling on either side.
    traffic_quiet = 1'b1;
    write_total(70);
    queue_random(75, 70);
    wait_idle();

    if (pending_answers.size() != 0) begin
      flag_error("answers still owed at end of run");
    end
    $display("Checked %0d answers: %0d nonzero grants, %0d exhausted allocations",
             answers_seen, grants_seen, refusals_seen);
    $display("Totals covered: 0, 1, 3, 5, 33, 40, 70, 100, 4096 and 8191; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_dpath.sv
hw/rtl/bitmap_page_allocator_core.sv
tb/tb_top.sv
